/* hw/rtl/complementary_attitude_filter_assert.svh */
// Assertion macros for the attitude filter. They sample on i_clk and are
// switched off while i_rst_n is low.
`ifndef COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH
`define COMPLEMENTARY_ATTITUDE_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/caf_pkg.sv */
package caf_pkg;

    // Configuration port.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd1;

    localparam logic [15:0] BLEND_WEIGHT_RST = 16'd58982;
    localparam logic [15:0] TIME_STEP_RST    = 16'd655;

    // CORDIC sizing.
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_TABLE_LEN   = 24;
    localparam int CORDIC_XY_W      = 35;
    localparam int CORDIC_Z_W       = 34;
    localparam int ANGLE_W          = 17;

    localparam logic signed [CORDIC_Z_W-1:0] PI_Q30 = 34'sd3373259426;

    // atan(2^-i) in Q.30.
    function automatic logic signed [CORDIC_Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [CORDIC_Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314857;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043837;
            5'd3:  v = 34'sd133525159;
            5'd4:  v = 34'sd67021687;
            5'd5:  v = 34'sd33543516;
            5'd6:  v = 34'sd16775851;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194283;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048576;
            5'd11: v = 34'sd524288;
            5'd12: v = 34'sd262144;
            5'd13: v = 34'sd131072;
            5'd14: v = 34'sd65536;
            5'd15: v = 34'sd32768;
            5'd16: v = 34'sd16384;
            5'd17: v = 34'sd8192;
            5'd18: v = 34'sd4096;
            5'd19: v = 34'sd2048;
            5'd20: v = 34'sd1024;
            5'd21: v = 34'sd512;
            5'd22: v = 34'sd256;
            5'd23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
    } t_in_req;

    typedef struct packed {
        logic signed [15:0] roll_q13;
        logic signed [15:0] pitch_q13;
    } t_out_req;

endpackage

/* hw/rtl/complementary_attitude_filter.sv */
// Roll and pitch complementary filter for one IMU sample per request.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries three
// accelerometer axes and the x and y gyro rates. Output channel
// (o_out_valid / i_out_ready / o_out_data) returns the updated roll and
// pitch estimates in Q3.13, one result request for every input request.
// Configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
// i_cfg_data) writes the blend weight (index 0) and the time step (index 1);
// it is always ready, and writes to other indexes are dropped.
// A single multiplier and a single CORDIC stage are reused; the two atan2
// evaluations run one after the other, each over all CORDIC steps (16 by
// default), so a new sample is taken only after the last one is finished.
// o_in_ready is high only while the sequencer is idle.
// Reset (synchronous, active low) clears both estimates to zero, loads the
// default blend weight and time step, and empties the output register.
// If the receiver stalls, the finished result waits in the sequencer until
// the output register is free; no result is ever dropped.
module complementary_attitude_filter
    import caf_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_req              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_req             o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    // The CORDIC never runs past the length of the arctangent table.
    localparam int NSTEPS = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STEPS;
    localparam int STEP_W = $clog2(NSTEPS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEPS - 1);

    // Sequencer: two gyro products, two CORDIC runs, four blend products,
    // then the hand-off to the output register.
    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_MUL_GX  = 12'b0000_0000_0010,
        S_MUL_GY  = 12'b0000_0000_0100,
        S_CINIT_R = 12'b0000_0000_1000,
        S_CITER_R = 12'b0000_0001_0000,
        S_CINIT_P = 12'b0000_0010_0000,
        S_CITER_P = 12'b0000_0100_0000,
        S_BL_R0   = 12'b0000_1000_0000,
        S_BL_R1   = 12'b0001_0000_0000,
        S_BL_P0   = 12'b0010_0000_0000,
        S_BL_P1   = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [15:0] r_blend_weight;
    logic [15:0] r_time_step;

    // The output register doubles as the filter state: the estimates are
    // always the last returned result.
    t_out_req r_out;
    logic     r_out_valid;

    // Working registers of one sample.
    t_in_req                         r_in;
    logic signed [36:0]              r_prod;
    logic signed [36:0]              r_acc;
    logic signed [18:0]              r_roll_sum;
    logic signed [18:0]              r_pitch_sum;
    logic signed [ANGLE_W-1:0]       r_ang_roll;
    logic signed [ANGLE_W-1:0]       r_ang_pitch;
    logic signed [15:0]              r_roll_new;
    logic signed [CORDIC_XY_W-1:0]   r_cx;
    logic signed [CORDIC_XY_W-1:0]   r_cy;
    logic signed [CORDIC_Z_W-1:0]    r_cz;
    logic                            r_zero;
    logic [STEP_W-1:0]               r_step;

    logic in_take;
    logic out_free;

    assign in_take  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Shared multiplier. Every product is registered in r_prod before it
    // is used, so the multiplier never feeds an adder in the same cycle.
    // ------------------------------------------------------------------
    logic        [16:0] w_acc_weight;
    logic signed [17:0] w_mul_a;
    logic signed [18:0] w_mul_b;
    logic signed [36:0] w_prod;

    // The accelerometer path weight is 65536 - a, which is the full 65536
    // when a is zero.
    assign w_acc_weight = 17'h10000 - {1'b0, r_blend_weight};

    // While a finished result waits for the output register, the last
    // pitch product is recomputed so that r_prod keeps its value.
    always_comb begin
        unique case (r_state)
            S_MUL_GY: begin
                w_mul_a = signed'({2'b00, r_time_step});
                w_mul_b = 19'(r_in.gyro_y);
            end
            S_BL_R0: begin
                w_mul_a = signed'({2'b00, r_blend_weight});
                w_mul_b = r_roll_sum;
            end
            S_BL_R1: begin
                w_mul_a = signed'({1'b0, w_acc_weight});
                w_mul_b = 19'(r_ang_roll);
            end
            S_BL_P0: begin
                w_mul_a = signed'({2'b00, r_blend_weight});
                w_mul_b = r_pitch_sum;
            end
            S_BL_P1, S_DONE: begin
                w_mul_a = signed'({1'b0, w_acc_weight});
                w_mul_b = 19'(r_ang_pitch);
            end
            default: begin
                w_mul_a = signed'({2'b00, r_time_step});
                w_mul_b = 19'(r_in.gyro_x);
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // The gyro increment dt*rate is Q.28; round half up into Q3.13.
    logic signed [17:0] w_drate;
    assign w_drate = 18'((r_prod + 37'sd16384) >>> 15);

    // Blend: the two weighted terms are Q.29; round half up into Q3.13 and
    // clamp to the 16-bit range.
    logic signed [37:0] w_bsum;
    logic signed [37:0] w_bshift;
    logic signed [15:0] w_bsat;

    assign w_bsum   = 38'(r_acc) + 38'(r_prod);
    assign w_bshift = (w_bsum + 38'sd32768) >>> 16;

    always_comb begin
        priority if (w_bshift > 38'sd32767) begin
            w_bsat = 16'sh7FFF;
        end else if (w_bshift < -38'sd32768) begin
            w_bsat = -16'sh8000;
        end else begin
            w_bsat = 16'(w_bshift);
        end
    end

    // ------------------------------------------------------------------
    // Shared CORDIC stage in vectoring mode. Operands are scaled by 2^16;
    // a vector in the left half plane is mirrored first and starts at +pi
    // or -pi, so the rotation only ever has to cover the right half plane.
    // ------------------------------------------------------------------
    logic signed [15:0]            w_op_y;
    logic signed [CORDIC_XY_W-1:0] w_x0;
    logic signed [CORDIC_XY_W-1:0] w_y0;
    logic signed [CORDIC_XY_W-1:0] w_dx;
    logic signed [CORDIC_XY_W-1:0] w_dy;
    logic signed [CORDIC_Z_W-1:0]  w_atan;
    logic signed [ANGLE_W-1:0]     w_ang;

    assign w_op_y = (r_state == S_CINIT_R) ? r_in.accel_y : r_in.accel_x;
    assign w_x0   = CORDIC_XY_W'(r_in.accel_z) <<< 16;
    assign w_y0   = CORDIC_XY_W'(w_op_y) <<< 16;
    assign w_dx   = r_cy >>> r_step;
    assign w_dy   = r_cx >>> r_step;
    assign w_atan = atan_q30(5'(r_step));

    // Final angle from Q.30 to Q3.13, rounded half up; atan2(0, 0) is zero.
    assign w_ang = r_zero ? '0 : ANGLE_W'((r_cz + 34'sd65536) >>> 17);

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_take) n_state = S_MUL_GX;
            S_MUL_GX:  n_state = S_MUL_GY;
            S_MUL_GY:  n_state = S_CINIT_R;
            S_CINIT_R: n_state = S_CITER_R;
            S_CITER_R: if (r_step == STEP_LAST) n_state = S_CINIT_P;
            S_CINIT_P: n_state = S_CITER_P;
            S_CITER_P: if (r_step == STEP_LAST) n_state = S_BL_R0;
            S_BL_R0:   n_state = S_BL_R1;
            S_BL_R1:   n_state = S_BL_P0;
            S_BL_P0:   n_state = S_BL_P1;
            S_BL_P1:   n_state = S_DONE;
            S_DONE:    if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Control state, configuration and the estimates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_blend_weight <= BLEND_WEIGHT_RST;
            r_time_step    <= TIME_STEP_RST;
            r_out          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_BLEND_WEIGHT) begin
                    r_blend_weight <= i_cfg_data;
                end else if (i_cfg_index == CFG_TIME_STEP) begin
                    r_time_step <= i_cfg_data;
                end
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_DONE && out_free) begin
                r_out.roll_q13  <= r_roll_new;
                r_out.pitch_q13 <= w_bsat;
                r_out_valid     <= 1'b1;
            end
        end
    end

    // Datapath registers of the sample in flight.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end

        r_prod <= w_prod;

        unique case (r_state)
            S_MUL_GY: begin
                r_roll_sum <= 19'(r_out.roll_q13) + 19'(w_drate);
            end
            S_CINIT_R, S_CINIT_P: begin
                if (r_state == S_CINIT_R) begin
                    r_pitch_sum <= 19'(r_out.pitch_q13) - 19'(w_drate);
                end else begin
                    r_ang_roll <= w_ang;
                end
                r_zero <= (r_in.accel_z == '0) && (w_op_y == '0);
                r_step <= '0;
                if (r_in.accel_z < 0) begin
                    r_cx <= -w_x0;
                    r_cy <= -w_y0;
                    r_cz <= (w_op_y >= 0) ? PI_Q30 : -PI_Q30;
                end else begin
                    r_cx <= w_x0;
                    r_cy <= w_y0;
                    r_cz <= '0;
                end
            end
            S_CITER_R, S_CITER_P: begin
                r_step <= r_step + 1'b1;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + w_dx;
                    r_cy <= r_cy - w_dy;
                    r_cz <= r_cz + w_atan;
                end else begin
                    r_cx <= r_cx - w_dx;
                    r_cy <= r_cy + w_dy;
                    r_cz <= r_cz - w_atan;
                end
            end
            S_BL_R0: begin
                r_ang_pitch <= w_ang;
            end
            S_BL_R1, S_BL_P1: begin
                r_acc <= r_prod;
            end
            S_BL_P0: begin
                r_roll_new <= w_bsat;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`include "complementary_attitude_filter_assert.svh"

    `CAF_ASSERT_NEXT(a_take_starts_work, in_take, r_state == S_MUL_GX, "accepted sample did not start the sequencer")
    `CAF_ASSERT_NEXT(a_done_hands_off, (r_state == S_DONE) && out_free, o_out_valid && (r_state == S_IDLE), "finished result not moved to the output register")
    `CAF_ASSERT_NOW(a_roll_cordic_full, r_state == S_CINIT_P, $past(r_step) == STEP_LAST, "roll CORDIC left before its last step")
    `CAF_ASSERT_NOW(a_pitch_cordic_full, r_state == S_BL_R0, $past(r_step) == STEP_LAST, "pitch CORDIC left before its last step")

endmodule
